// ===== sv/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types, codes and defaults for the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int NUM_SLOTS_DEF  = 256;
	localparam int WAIT_DEPTH_DEF = 256;
	localparam int DELAY_W        = 4;
	localparam int GEN_W          = 16;
	localparam logic [DELAY_W-1:0] DELAY_RST = 4'd2;

	typedef enum logic [2:0] {
		MODE_REQ_P  = 3'd0,
		MODE_REQ_T  = 3'd1,
		MODE_FREE_P = 3'd2,
		MODE_FREE_T = 3'd3,
		MODE_TICK   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_EXH  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

endpackage

// ===== sv/gsa_if.sv =====
// ----------------------------------------------------------------------------
// gsa_in_if / gsa_out_if
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
interface gsa_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] slot_id;
	modport source (output valid, mode, slot_id, input ready);
	modport sink   (input valid, mode, slot_id, output ready);
endinterface

interface gsa_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  slot_out;
	logic [15:0] generation_out;
	logic [1:0]  status;
	modport source (output valid, slot_out, generation_out, status, input ready);
	modport sink   (input valid, slot_out, generation_out, status, output ready);
endinterface

// ===== sv/gsa_ram.sv =====
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/generational_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Slot allocator with LIFO free stack, generations and deferred release.
// ----------------------------------------------------------------------------
//  channel  dir  transfer on            payload
//  in_ch    in   valid & ready          mode, slot_id
//  out_ch   out  valid & ready          slot_out, generation_out, status
//  cfg      in   cfg_we                 cfg_wdata (frame_delay)
//
// A free or fresh request goes straight to the result; a reused request
// first reads the stack, and a persistent one then does the generation
// read-modify-write. A frame tick is paced by the single read port of
// each pending-list RAM (walk down, then compact upward over every entry).
// Reset clears counters and flags, loads DELAY_RST; RAMs need no clearing pass.
// A result waits in the output register; the next command is taken meanwhile.
module generational_slot_allocator #(
	parameter int NUM_SLOTS  = gsa_pkg::NUM_SLOTS_DEF,
	parameter int WAIT_DEPTH = gsa_pkg::WAIT_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gsa_pkg::DELAY_W-1:0]  cfg_wdata,
	gsa_in_if.sink                       in_ch,
	gsa_out_if.source                    out_ch
);
	import gsa_pkg::*;

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int FW = $clog2(NUM_SLOTS + 1);
	localparam int LA = $clog2(WAIT_DEPTH);
	localparam int LW = $clog2(WAIT_DEPTH + 1);
	localparam int EW = SW + DELAY_W;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_POP    = 8'b0000_0010,
		S_GEN    = 8'b0000_0100,
		S_WA_RD  = 8'b0000_1000,
		S_WA_CHK = 8'b0001_0000,
		S_WB_RD  = 8'b0010_0000,
		S_WB_CHK = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [DELAY_W-1:0] delay_q;
	logic [FW-1:0]      fc_q, nf_q, fc_m1;
	logic [LW-1:0]      tlen_q, plen_q, idx_q, w_q, idx_m1, cur_len;
	logic               lsel_q, pers_q;
	logic [SW-1:0]      slot_q, sid;
	logic [7:0]         res_slot_q;
	logic [GEN_W-1:0]   res_gen_q;
	status_t            res_st_q;
	logic               ov_q;
	logic [7:0]         out_slot_q;
	logic [GEN_W-1:0]   out_gen_q;
	logic [1:0]         out_st_q;
	logic               fire, in_rng;

	logic               stk_we, gen_we, t_we, p_we;
	logic [SW-1:0]      stk_waddr, stk_rdata, gen_waddr;
	logic [GEN_W-1:0]   gen_wdata, gen_rdata;
	logic [LA-1:0]      l_waddr, l_raddr;
	logic [EW-1:0]      l_wdata, t_rdata, p_rdata, l_rdata;
	logic [SW-1:0]      lst_id;
	logic [DELAY_W-1:0] lst_cnt;

	assign fire    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign fc_m1   = fc_q - 1'b1;
	assign idx_m1  = idx_q - 1'b1;
	assign cur_len = lsel_q ? plen_q : tlen_q;
	assign sid     = SW'(in_ch.slot_id);
	assign in_rng  = (32'(in_ch.slot_id) < 32'(NUM_SLOTS));
	assign l_rdata = lsel_q ? p_rdata : t_rdata;
	assign lst_id  = l_rdata[EW-1:DELAY_W];
	assign lst_cnt = l_rdata[DELAY_W-1:0];

	assign out_ch.valid          = ov_q;
	assign out_ch.slot_out       = out_slot_q;
	assign out_ch.generation_out = out_gen_q;
	assign out_ch.status         = out_st_q;

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = fc_q[SW-1:0];
		gen_we    = 1'b0;
		gen_waddr = nf_q[SW-1:0];
		gen_wdata = '0;
		t_we      = 1'b0;
		p_we      = 1'b0;
		l_waddr   = w_q[LA-1:0];
		l_wdata   = {lst_id, lst_cnt - 1'b1};
		l_raddr   = idx_q[LA-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_ch.mode == MODE_FREE_P) begin
					l_waddr = plen_q[LA-1:0];
				end else begin
					l_waddr = tlen_q[LA-1:0];
				end
				l_wdata = {sid, delay_q};
				if (fire) begin
					case (in_ch.mode)
						MODE_REQ_P, MODE_REQ_T: begin
							gen_we = (fc_q == '0) && (nf_q < FW'(NUM_SLOTS));
						end
						MODE_FREE_P: p_we = in_rng && (plen_q < LW'(WAIT_DEPTH));
						MODE_FREE_T: t_we = in_rng && (tlen_q < LW'(WAIT_DEPTH));
						default: ;
					endcase
				end
			end
			S_GEN: begin
				gen_we    = 1'b1;
				gen_waddr = slot_q;
				gen_wdata = gen_rdata + 1'b1;
			end
			S_WA_RD: l_raddr = idx_m1[LA-1:0];
			S_WA_CHK: stk_we = (lst_cnt == '0) && (fc_q < FW'(NUM_SLOTS));
			S_WB_CHK: begin
				t_we = (lst_cnt != '0) && !lsel_q;
				p_we = (lst_cnt != '0) && lsel_q;
			end
			default: ;
		endcase
	end

	gsa_ram #(.W(SW), .D(NUM_SLOTS)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(lst_id),
		.raddr(fc_m1[SW-1:0]), .rdata(stk_rdata)
	);
	gsa_ram #(.W(GEN_W), .D(NUM_SLOTS)) u_gen (
		.clk(clk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
		.raddr(stk_rdata), .rdata(gen_rdata)
	);
	gsa_ram #(.W(EW), .D(WAIT_DEPTH)) u_tlist (
		.clk(clk), .we(t_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(t_rdata)
	);
	gsa_ram #(.W(EW), .D(WAIT_DEPTH)) u_plist (
		.clk(clk), .we(p_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(p_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			delay_q <= DELAY_RST;
			fc_q    <= '0;
			nf_q    <= '0;
			tlen_q  <= '0;
			plen_q  <= '0;
			idx_q   <= '0;
			w_q     <= '0;
			lsel_q  <= 1'b0;
			pers_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (ov_q && out_ch.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						res_slot_q <= '0;
						res_gen_q  <= '0;
						res_st_q   <= ST_OK;
						state_q    <= S_DONE;
						case (in_ch.mode)
							MODE_REQ_P, MODE_REQ_T: begin
								if (fc_q != '0) begin
									fc_q    <= fc_m1;
									pers_q  <= (in_ch.mode == MODE_REQ_P);
									state_q <= S_POP;
								end else if (nf_q < FW'(NUM_SLOTS)) begin
									res_slot_q <= 8'(nf_q[SW-1:0]);
									nf_q       <= nf_q + 1'b1;
								end else begin
									res_st_q <= ST_EXH;
								end
							end
							MODE_FREE_P: begin
								if (in_rng && plen_q == LW'(WAIT_DEPTH)) begin
									res_st_q <= ST_FULL;
								end else if (in_rng) begin
									plen_q <= plen_q + 1'b1;
								end
							end
							MODE_FREE_T: begin
								if (in_rng && tlen_q == LW'(WAIT_DEPTH)) begin
									res_st_q <= ST_FULL;
								end else if (in_rng) begin
									tlen_q <= tlen_q + 1'b1;
								end
							end
							MODE_TICK: begin
								lsel_q  <= 1'b0;
								idx_q   <= tlen_q;
								state_q <= S_WA_RD;
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					slot_q     <= stk_rdata;
					res_slot_q <= 8'(stk_rdata);
					state_q    <= pers_q ? S_GEN : S_DONE;
				end
				S_GEN: begin
					res_gen_q <= gen_rdata + 1'b1;
					state_q   <= S_DONE;
				end
				S_WA_RD: begin
					if (idx_q == '0) begin
						w_q     <= '0;
						state_q <= S_WB_RD;
					end else begin
						idx_q   <= idx_m1;
						state_q <= S_WA_CHK;
					end
				end
				S_WA_CHK: begin
					if (stk_we) begin
						fc_q <= fc_q + 1'b1;
					end
					state_q <= S_WA_RD;
				end
				S_WB_RD: begin
					if (idx_q == cur_len) begin
						if (!lsel_q) begin
							tlen_q  <= w_q;
							lsel_q  <= 1'b1;
							idx_q   <= plen_q;
							state_q <= S_WA_RD;
						end else begin
							plen_q  <= w_q;
							state_q <= S_DONE;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_WB_CHK;
					end
				end
				S_WB_CHK: begin
					if (lst_cnt != '0) begin
						w_q <= w_q + 1'b1;
					end
					state_q <= S_WB_RD;
				end
				S_DONE: begin
					if (!ov_q || out_ch.ready) begin
						ov_q       <= 1'b1;
						out_slot_q <= res_slot_q;
						out_gen_q  <= res_gen_q;
						out_st_q   <= res_st_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FW'(NUM_SLOTS)) else $error("free count beyond pool");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		tlen_q <= LW'(WAIT_DEPTH) && plen_q <= LW'(WAIT_DEPTH))
		else $error("pending length beyond depth");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !in_ch.ready) else $error("command taken while busy");
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB_CHK |-> w_q < idx_q) else $error("compaction overtakes read");
`endif

endmodule
